FILE: rtl/smooth_weighted_round_robin_picker_top_macros.svh
// Assertion macros used by the picker's controller.
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_PICKER_TOP_MACROS_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_PICKER_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SWRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked while out of reset
`define SWRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/swrr_pkg.sv
// Shared constants and controller/datapath interface types for the picker.
package swrr_pkg;

    localparam int INSTANCES   = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int CREDIT_BITS = WEIGHT_BITS + 5;
    localparam int IDX_BITS    = $clog2(INSTANCES);
    localparam int FIELD_IDX_BITS = 3;

    localparam logic CMD_SET_WEIGHT = 1'b0;
    localparam logic CMD_PICK       = 1'b1;

    typedef struct packed {
        logic set_weight;
        logic walk_start;
        logic walk_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/smooth_weighted_round_robin_picker_top.sv
// Smooth weighted round-robin picker: after a set-weight beat the block accepts the next beat in
// the following cycle. A pick beat is accepted, then the datapath walks the eight instances
// in turn through a single credit adder and running-maximum compare, and last writes back
// the winner's credit and loads the result register. A pick result waits in that register
// while the next beat is accepted; a second pick stalls at its end until the first result
// has been taken. Set-weight beats give no result. Reset clears all weights and credits
// at once.
module smooth_weighted_round_robin_picker_top
    import swrr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic [FIELD_IDX_BITS-1:0] i_instance_index,
    input  logic [WEIGHT_BITS-1:0]    i_weight_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_pick_valid,
    output logic [FIELD_IDX_BITS-1:0] o_picked_index
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    swrr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_status  (w_status),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd)
    );

    swrr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_instance_index (i_instance_index),
        .i_weight_value   (i_weight_value),
        .i_stall          (i_stall),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_pick_valid     (o_pick_valid),
        .o_picked_index   (o_picked_index)
    );

endmodule

FILE: rtl/swrr_ctrl.sv
// Sequencer for the picker: accepts beats, steps the table walk, hands off results.
module swrr_ctrl
    import swrr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_command,
    input  t_dp_status i_status,
    output logic       o_stall,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_PICK) begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = ST_WALK;
                    end else begin
                        o_cmd.set_weight = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the beat
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`include "smooth_weighted_round_robin_picker_top_macros.svh"

    `SWRR_ASSERT_NEXT(a_walk_holds, r_state == ST_WALK && !i_status.walk_last, r_state == ST_WALK)
    `SWRR_ASSERT_NEXT(a_pick_starts_walk, w_accept && i_command == CMD_PICK, r_state == ST_WALK)
    `SWRR_ASSERT_NOW(a_load_needs_room, o_cmd.load_out, i_status.out_free)

endmodule

FILE: rtl/swrr_dp.sv
// Weight and credit tables, serial credit walk with running maximum, output register.
module swrr_dp
    import swrr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [FIELD_IDX_BITS-1:0] i_instance_index,
    input  logic [WEIGHT_BITS-1:0]    i_weight_value,
    input  logic                      i_stall,
    output t_dp_status                o_status,
    output logic                      o_valid,
    output logic                      o_pick_valid,
    output logic [FIELD_IDX_BITS-1:0] o_picked_index
);

    localparam int SUM_BITS   = CREDIT_BITS + 1;
    localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;
    localparam int PAD_BITS   = SUM_BITS - CREDIT_BITS + 1;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {{PAD_BITS{1'b0}}, {(CREDIT_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {{PAD_BITS{1'b1}}, {(CREDIT_BITS-1){1'b0}}};

    typedef logic signed [CREDIT_BITS-1:0] t_credit;
    typedef logic [IDX_BITS-1:0]           t_idx;

    function automatic t_credit sat_credit(input logic signed [SUM_BITS-1:0] v);
        t_credit res;
        if (v > SUM_MAX) begin
            res = t_credit'(SUM_MAX);
        end else if (v < SUM_MIN) begin
            res = t_credit'(SUM_MIN);
        end else begin
            res = t_credit'(v);
        end
        return res;
    endfunction

    logic [WEIGHT_BITS-1:0] r_weight [INSTANCES];
    t_credit                r_credit [INSTANCES];
    logic [INSTANCES-1:0]   r_present;

    t_idx                   r_ptr;
    t_idx                   r_best;
    t_credit                r_best_credit;
    logic                   r_found;
    logic [TOTAL_BITS-1:0]  r_total;

    logic                      r_out_valid;
    logic                      r_pick_valid;
    logic [FIELD_IDX_BITS-1:0] r_picked_index;

    t_idx                   w_set_idx;
    logic                   w_set_in_range;
    t_credit                w_step_credit;
    t_credit                w_final_credit;
    logic                   w_take;

    assign w_set_idx      = t_idx'(i_instance_index);
    assign w_set_in_range = (32'(i_instance_index) < INSTANCES);

    assign w_step_credit  = sat_credit(SUM_BITS'(r_credit[r_ptr])
                          + SUM_BITS'(signed'({1'b0, r_weight[r_ptr]})));
    assign w_final_credit = sat_credit(SUM_BITS'(r_best_credit)
                          - SUM_BITS'(signed'({1'b0, r_total})));

    assign w_take = r_out_valid && !i_stall;

    assign o_status.walk_last = (r_ptr == t_idx'(INSTANCES - 1));
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_pick_valid   = r_pick_valid;
    assign o_picked_index = r_picked_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < INSTANCES; i++) begin
                r_weight[i] <= '0;
                r_credit[i] <= '0;
            end
            r_present   <= '0;
            r_ptr       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.set_weight && w_set_in_range) begin
                if (i_weight_value == '0) begin
                    r_weight[w_set_idx]  <= '0;
                    r_credit[w_set_idx]  <= '0;
                    r_present[w_set_idx] <= 1'b0;
                end else begin
                    // an instance joining afresh starts from zero credit
                    if (!r_present[w_set_idx]) begin
                        r_credit[w_set_idx] <= '0;
                    end
                    r_weight[w_set_idx]  <= i_weight_value;
                    r_present[w_set_idx] <= 1'b1;
                end
            end

            if (i_cmd.walk_start) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
                r_total <= '0;
            end

            if (i_cmd.walk_step) begin
                r_ptr <= r_ptr + t_idx'(1);
                if (r_present[r_ptr]) begin
                    r_credit[r_ptr] <= w_step_credit;
                    r_total         <= r_total + TOTAL_BITS'(r_weight[r_ptr]);
                    // strict compare keeps the lowest index on a tie
                    if (!r_found || w_step_credit > r_best_credit) begin
                        r_best        <= r_ptr;
                        r_best_credit <= w_step_credit;
                        r_found       <= 1'b1;
                    end
                end
            end

            if (i_cmd.load_out) begin
                if (r_found) begin
                    r_credit[r_best] <= w_final_credit;
                end
                r_out_valid    <= 1'b1;
                r_pick_valid   <= r_found;
                r_picked_index <= r_found ? FIELD_IDX_BITS'(r_best) : '0;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
